FILE: src/sptq_pkg.sv
// shared types, codes and constants of the sorted priority table
`default_nettype none
package sptq_pkg;

	// table size default and field widths
	localparam int DEPTH_DEF = 32;
	localparam int TICKET_W  = 16;
	localparam int AGE_W     = 8;
	localparam int SEV_W     = 3;
	localparam int POS_W     = 6;
	localparam int TOTAL_W   = 7;
	localparam int STATUS_W  = 3;
	localparam int REQ_W     = 3;

	localparam logic [SEV_W-1:0] SEV_MIN = SEV_W'(1);
	localparam logic [SEV_W-1:0] SEV_MAX = SEV_W'(4);

	// request codes
	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT = 3'd0,
		REQ_LOOKUP = 3'd1,
		REQ_UPDATE = 3'd2,
		REQ_REMOVE = 3'd3,
		REQ_READ   = 3'd4
	} req_code_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_DUP      = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_BADSEV   = 3'd4
	} status_code_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_EVAL,
		S_MOVE,
		S_DONE
	} fsm_t;

	// one table entry as held by a cell
	typedef struct packed {
		logic [TICKET_W-1:0] ticket;
		logic [AGE_W-1:0]    age;
		logic [SEV_W-1:0]    severity;
	} entry_t;

	// input item
	typedef struct packed {
		logic [REQ_W-1:0]    req_type;
		logic [TICKET_W-1:0] ticket;
		logic [AGE_W-1:0]    age;
		logic [SEV_W-1:0]    severity;
		logic [POS_W-1:0]    position;
	} req_t;

	// result item
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [TICKET_W-1:0] out_ticket;
		logic [AGE_W-1:0]    out_age;
		logic [SEV_W-1:0]    out_severity;
		logic [POS_W-1:0]    out_index;
		logic [TOTAL_W-1:0]  entry_total;
	} rsp_t;

endpackage
`default_nettype wire

FILE: src/sptq_stream_if.sv
// valid/ready channel carrying one item of a given payload type
`default_nettype none
interface sptq_stream_if #(
	parameter type payload_t = logic [0:0]
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/sptq_cell.sv
// one cell of the entry ring: holds one entry, takes its neighbor's on shift
`default_nettype none
module sptq_cell import sptq_pkg::*; (
	input  logic   clk,
	input  logic   shift,
	input  entry_t d,
	output entry_t q
);
	entry_t ent_q;

	// load the neighbor's entry when the ring moves
	always_ff @(posedge clk) begin
		if (shift) begin
			ent_q <= d;
		end
	end

	assign q = ent_q;
endmodule
`default_nettype wire

FILE: src/sorted_priority_table.sv
// top level: sorted priority table on a ring of entry cells
//
//   channel | dir | payload                                        | accepted when
//   req     | in  | req_type, ticket, age, severity, position      | valid & ready
//   rsp     | out | status, out_ticket, out_age, out_severity,     | valid & ready
//           |     | out_index, entry_total                         |
//
// Every item makes one full turn of the DEPTH-cell ring to search it, then passes
// through a decide state. Insert, update and remove that succeed take a second turn
// that rewrites the ring in order before the result is loaded into the output
// register.
// Reset clears the entry count and the control state; cell contents stay as they are.
// One item is in work at a time; a result waiting on rsp does not stop the next
// item from being accepted, only its result waits for the register to free up.
`default_nettype none
module sorted_priority_table import sptq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	sptq_stream_if.sink   req,
	sptq_stream_if.source rsp
);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] LAST  = CW'(DEPTH - 1);
	localparam logic [CW-1:0] NONE  = CW'(DEPTH);

	// ring of cells
	entry_t cell_q [DEPTH];
	entry_t ring_in;
	logic   shift;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == DEPTH - 1) begin : g_tail
			sptq_cell u_cell (.clk(clk), .shift(shift), .d(ring_in), .q(cell_q[i]));
		end else begin : g_body
			sptq_cell u_cell (.clk(clk), .shift(shift), .d(cell_q[i+1]), .q(cell_q[i]));
		end
	end

	// control and work registers
	fsm_t          st_q, st_d;
	logic [CW-1:0] count_q;
	logic [CW-1:0] k_q;
	req_t          op_q;
	logic          found_q;
	logic [CW-1:0] fidx_q;
	entry_t        fent_q;
	logic [CW-1:0] lt_q;
	entry_t        rd_q;
	entry_t        prev_q;
	entry_t        new_q;
	logic [CW-1:0] ins_q;
	logic [CW-1:0] del_q;
	rsp_t          res_q;
	logic          rsp_vld_q;
	rsp_t          rsp_data_q;

	entry_t head;
	entry_t head_nxt;
	entry_t new_ent;
	entry_t red;
	logic   valid_k;
	logic   hit;
	logic   less;
	logic   sev_ok;
	logic   accept;
	logic   load_rsp;
	logic   at_last;

	// eval results
	rsp_t          ev_res;
	logic [CW-1:0] ev_count;
	logic [CW-1:0] ev_ins;
	logic [CW-1:0] ev_del;
	logic          ev_move;

	assign head     = cell_q[0];
	assign head_nxt = cell_q[1];
	assign at_last  = (k_q == LAST);
	assign accept   = req.valid && req.ready;
	assign new_ent  = '{ticket: op_q.ticket, age: op_q.age, severity: op_q.severity};
	assign sev_ok   = (op_q.severity >= SEV_MIN) && (op_q.severity <= SEV_MAX);

	// scan compares on the head cell
	assign valid_k = (k_q < count_q);
	assign hit     = valid_k && (head.ticket == op_q.ticket);
	assign less    = valid_k && !hit &&
		({head.severity, head.ticket} < {op_q.severity, op_q.ticket});

	// list with the removed entry taken out, seen at the head
	assign red = (k_q < del_q) ? head : head_nxt;

	// decision after the search turn
	always_comb begin
		ev_res   = '0;
		ev_res.status = ST_NOTFOUND;
		ev_count = count_q;
		ev_ins   = NONE;
		ev_del   = NONE;
		ev_move  = 1'b0;
		unique case (op_q.req_type)
			REQ_INSERT: begin
				if (!sev_ok) begin
					ev_res.status = ST_BADSEV;
				end else if (count_q >= NONE) begin
					ev_res.status = ST_FULL;
				end else if (found_q) begin
					ev_res.status = ST_DUP;
				end else begin
					ev_res.status       = ST_OK;
					ev_res.out_ticket   = new_ent.ticket;
					ev_res.out_age      = new_ent.age;
					ev_res.out_severity = new_ent.severity;
					ev_res.out_index    = POS_W'(lt_q);
					ev_ins   = lt_q;
					ev_count = count_q + CW'(1);
					ev_move  = 1'b1;
				end
			end
			REQ_LOOKUP: begin
				if (found_q) begin
					ev_res.status       = ST_OK;
					ev_res.out_ticket   = fent_q.ticket;
					ev_res.out_age      = fent_q.age;
					ev_res.out_severity = fent_q.severity;
					ev_res.out_index    = POS_W'(fidx_q);
				end
			end
			REQ_UPDATE: begin
				if (found_q && !sev_ok) begin
					ev_res.status = ST_BADSEV;
				end else if (found_q) begin
					ev_res.status       = ST_OK;
					ev_res.out_ticket   = new_ent.ticket;
					ev_res.out_age      = new_ent.age;
					ev_res.out_severity = new_ent.severity;
					ev_res.out_index    = POS_W'(lt_q);
					ev_ins  = lt_q;
					ev_del  = fidx_q;
					ev_move = 1'b1;
				end
			end
			REQ_REMOVE: begin
				if (found_q) begin
					ev_res.status       = ST_OK;
					ev_res.out_ticket   = fent_q.ticket;
					ev_res.out_age      = fent_q.age;
					ev_res.out_severity = fent_q.severity;
					ev_res.out_index    = POS_W'(fidx_q);
					ev_del   = fidx_q;
					ev_count = count_q - CW'(1);
					ev_move  = 1'b1;
				end
			end
			REQ_READ: begin
				if (TOTAL_W'(op_q.position) < TOTAL_W'(count_q)) begin
					ev_res.status       = ST_OK;
					ev_res.out_ticket   = rd_q.ticket;
					ev_res.out_age      = rd_q.age;
					ev_res.out_severity = rd_q.severity;
					ev_res.out_index    = op_q.position;
				end
			end
			default: begin
				ev_res.status = ST_NOTFOUND;
			end
		endcase
		ev_res.entry_total = TOTAL_W'(ev_count);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// next state and ring control
	always_comb begin
		st_d     = st_q;
		shift    = 1'b0;
		ring_in  = head;
		load_rsp = 1'b0;
		req.ready = 1'b0;
		unique case (st_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					st_d = S_SCAN;
				end
			end
			S_SCAN: begin
				shift = 1'b1;
				if (at_last) begin
					st_d = S_EVAL;
				end
			end
			S_EVAL: begin
				st_d = ev_move ? S_MOVE : S_DONE;
			end
			S_MOVE: begin
				shift = 1'b1;
				if (k_q < ins_q) begin
					ring_in = red;
				end else if (k_q == ins_q) begin
					ring_in = new_q;
				end else begin
					ring_in = prev_q;
				end
				if (at_last) begin
					st_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!rsp_vld_q || rsp.ready) begin
					load_rsp = 1'b1;
					st_d     = S_IDLE;
				end
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (st_q == S_EVAL) begin
			count_q <= ev_count;
		end
	end

	// work registers of the search and rewrite turns
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= req.data;
			k_q     <= '0;
			found_q <= 1'b0;
			lt_q    <= '0;
		end else if (st_q == S_SCAN) begin
			k_q <= at_last ? '0 : k_q + CW'(1);
			if (hit && !found_q) begin
				found_q <= 1'b1;
				fidx_q  <= k_q;
				fent_q  <= head;
			end
			if (less) begin
				lt_q <= lt_q + CW'(1);
			end
			if (TOTAL_W'(op_q.position) == TOTAL_W'(k_q)) begin
				rd_q <= head;
			end
		end else if (st_q == S_EVAL) begin
			res_q <= ev_res;
			ins_q <= ev_ins;
			del_q <= ev_del;
			new_q <= new_ent;
			k_q   <= '0;
		end else if (st_q == S_MOVE) begin
			k_q    <= k_q + CW'(1);
			prev_q <= red;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_data_q <= res_q;
		end
	end

	assign rsp.valid = rsp_vld_q;
	assign rsp.data  = rsp_data_q;
endmodule
`default_nettype wire

FILE: tb/sv/tb_sorted_priority_table.sv
// testbench of the sorted priority table: random and directed requests against a predictor
`default_nettype none
module tb_sorted_priority_table;
	import sptq_pkg::*;

	localparam int TABLE_SIZE    = DEPTH_DEF;
	localparam int POOL_SIZE     = 40;
	localparam int RANDOM_BLOCKS = 13;
	localparam int BLOCK_LEN     = 60;
	localparam int HOLD_CYCLES   = 300;
	localparam int HOLD_AT_A     = 100;
	localparam int HOLD_AT_B     = 450;
	localparam int MAX_REPORTS   = 10;
	localparam logic [REQ_W-1:0] REQ_FIRST_UNUSED = 3'd5;
	localparam logic [REQ_W-1:0] REQ_MID_UNUSED   = 3'd6;
	localparam logic [REQ_W-1:0] REQ_LAST_UNUSED  = 3'd7;

	// request mixes of the random part
	typedef enum int {
		MIX_FILL,
		MIX_CHURN,
		MIX_DRAIN
	} mix_t;

	// request waiting to be offered, with its lead-in gap
	typedef struct {
		req_t        req;
		int unsigned gap;
		bit          wait_empty;
	} timed_req_t;

	logic clk;
	logic arst_n;

	sptq_stream_if #(.payload_t(req_t)) req_if ();
	sptq_stream_if #(.payload_t(rsp_t)) rsp_if ();

	sorted_priority_table #(
		.DEPTH(TABLE_SIZE)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	// predicted table contents in service order
	entry_t queue_entries [TABLE_SIZE];
	int     queue_fill;
	int     peak_fill;

	timed_req_t req_backlog [$];
	rsp_t       results_due [$];

	int unsigned idle_cycles;
	int          accepted_reqs;
	int          results_seen;
	int          stall_left;
	int          next_stall;
	int          fail_count;
	int          status_seen [8];
	rsp_t        want;
	rsp_t        got;

	// position of a ticket, or the fill level when absent
	function automatic int ticket_slot(input logic [TICKET_W-1:0] t);
		for (int i = 0; i < queue_fill; i++)
			if (queue_entries[i].ticket == t)
				return i;
		return queue_fill;
	endfunction

	// close the gap left by a removed entry
	function automatic void drop_slot(input int slot);
		for (int i = slot; i + 1 < queue_fill; i++)
			queue_entries[i] = queue_entries[i + 1];
		queue_fill--;
	endfunction

	// insert in service order, caller makes sure there is room
	function automatic int place_entry(input entry_t e);
		int slot;
		slot = queue_fill;
		for (int i = 0; i < queue_fill; i++) begin
			if ({e.severity, e.ticket} <
					{queue_entries[i].severity, queue_entries[i].ticket}) begin
				slot = i;
				break;
			end
		end
		for (int i = queue_fill; i > slot; i--)
			queue_entries[i] = queue_entries[i - 1];
		queue_entries[slot] = e;
		queue_fill++;
		return slot;
	endfunction

	// apply one request to the predicted table and build its result
	function automatic rsp_t serve_request(input req_t r);
		rsp_t         res;
		entry_t       e;
		int           slot;
		bit           sev_ok;
		status_code_t st;
		res        = '0;
		slot       = 0;
		e.ticket   = r.ticket;
		e.age      = r.age;
		e.severity = r.severity;
		sev_ok     = (r.severity >= SEV_MIN) && (r.severity <= SEV_MAX);
		st         = ST_NOTFOUND;
		case (r.req_type)
			REQ_INSERT: begin
				if (!sev_ok) begin
					st = ST_BADSEV;
				end else if (queue_fill >= TABLE_SIZE) begin
					st = ST_FULL;
				end else if (ticket_slot(r.ticket) < queue_fill) begin
					st = ST_DUP;
				end else begin
					slot = place_entry(e);
					st   = ST_OK;
				end
			end
			REQ_LOOKUP: begin
				slot = ticket_slot(r.ticket);
				if (slot < queue_fill) begin
					e  = queue_entries[slot];
					st = ST_OK;
				end
			end
			REQ_UPDATE: begin
				slot = ticket_slot(r.ticket);
				if (slot >= queue_fill) begin
					st = ST_NOTFOUND;
				end else if (!sev_ok) begin
					st = ST_BADSEV;
				end else begin
					drop_slot(slot);
					slot = place_entry(e);
					st   = ST_OK;
				end
			end
			REQ_REMOVE: begin
				slot = ticket_slot(r.ticket);
				if (slot < queue_fill) begin
					e = queue_entries[slot];
					drop_slot(slot);
					st = ST_OK;
				end
			end
			REQ_READ: begin
				if (int'(r.position) < queue_fill) begin
					slot = r.position;
					e    = queue_entries[slot];
					st   = ST_OK;
				end
			end
			default: st = ST_NOTFOUND;
		endcase
		res.status = st;
		if (st == ST_OK) begin
			res.out_ticket   = e.ticket;
			res.out_age      = e.age;
			res.out_severity = e.severity;
			res.out_index    = POS_W'(slot);
		end
		res.entry_total = TOTAL_W'(queue_fill);
		if (queue_fill > peak_fill)
			peak_fill = queue_fill;
		return res;
	endfunction

	function automatic req_t make_req(input logic [REQ_W-1:0] op, input logic [TICKET_W-1:0] t,
			input logic [AGE_W-1:0] a, input logic [SEV_W-1:0] s, input logic [POS_W-1:0] p);
		req_t r;
		r.req_type = op;
		r.ticket   = t;
		r.age      = a;
		r.severity = s;
		r.position = p;
		return r;
	endfunction

	task automatic push_req(input req_t r, input int unsigned gap, input bit wait_empty);
		timed_req_t item;
		item.req        = r;
		item.gap        = gap;
		item.wait_empty = wait_empty;
		req_backlog.push_back(item);
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#4_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// request driver: offers backlog items after their gap, holds until accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			req_if.data  <= '0;
			idle_cycles  <= 0;
		end else begin
			if (req_if.valid && req_if.ready) begin
				results_due.push_back(serve_request(req_if.data));
				accepted_reqs++;
			end
			if (req_if.valid && !req_if.ready) begin
				// item still on offer
			end else if (req_backlog.size() != 0 && idle_cycles >= req_backlog[0].gap &&
					!(req_backlog[0].wait_empty && results_due.size() != 0)) begin
				req_if.data  <= req_backlog[0].req;
				req_if.valid <= 1'b1;
				idle_cycles  <= 0;
				req_backlog.pop_front();
			end else begin
				req_if.valid <= 1'b0;
				idle_cycles  <= idle_cycles + 1;
			end
		end
	end

	// result monitor: random stalls, long hold-offs, field checks
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			stall_left   <= 0;
		end else begin
			next_stall = (stall_left > 0) ? stall_left - 1 : 0;
			if (rsp_if.valid && rsp_if.ready) begin
				got = rsp_if.data;
				results_seen++;
				if (results_due.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: result %0d arrived with none expected", $time,
							results_seen);
				end else begin
					want = results_due.pop_front();
					status_seen[want.status]++;
					if (got.status !== want.status || got.out_ticket !== want.out_ticket ||
							got.out_age !== want.out_age ||
							got.out_severity !== want.out_severity ||
							got.out_index !== want.out_index ||
							got.entry_total !== want.entry_total) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS) begin
							$display("%0t: result %0d expected st=%0d tk=%h age=%h sev=%0d idx=%0d tot=%0d",
								$time, results_seen, want.status, want.out_ticket, want.out_age,
								want.out_severity, want.out_index, want.entry_total);
							$display("%0t: result %0d actual   st=%0d tk=%h age=%h sev=%0d idx=%0d tot=%0d",
								$time, results_seen, got.status, got.out_ticket, got.out_age,
								got.out_severity, got.out_index, got.entry_total);
						end
					end
				end
				if (results_seen == HOLD_AT_A || results_seen == HOLD_AT_B)
					next_stall = HOLD_CYCLES;
				else if ((results_seen / 100) % 4 == 1)
					next_stall = 0;
				else
					next_stall = $urandom_range(0, 15);
			end
			stall_left   <= next_stall;
			rsp_if.ready <= (next_stall == 0);
		end
	end

	// stimulus, reset and end of run
	initial begin
		logic [TICKET_W-1:0] ticket_pool [POOL_SIZE];
		logic [REQ_W-1:0]    op;
		logic [TICKET_W-1:0] tk;
		logic [SEV_W-1:0]    sev;
		logic [POS_W-1:0]    pos;
		mix_t                mix;
		int                  roll;
		int                  ins_w;
		int                  rem_w;
		int unsigned         gap;
		int                  v;

		arst_n     = 1'b0;
		queue_fill = 0;
		peak_fill  = 0;
		fail_count = 0;

		// directed: extremes, tie order, duplicate, bad severity and not-found errors, unused codes
		push_req(make_req(REQ_INSERT, 16'h0000, 8'h00, 3'd1, 6'd0), $urandom_range(0, 15), 0);
		push_req(make_req(REQ_INSERT, 16'hFFFF, 8'hFF, 3'd4, 6'd63), $urandom_range(0, 15), 0);
		push_req(make_req(REQ_INSERT, 16'h1234, 8'h5A, 3'd4, 6'd0), $urandom_range(0, 15), 0);
		push_req(make_req(REQ_INSERT, 16'h8000, 8'hA5, 3'd2, 6'd0), $urandom_range(0, 15), 0);
		push_req(make_req(REQ_INSERT, 16'h4321, 8'h11, 3'd0, 6'd0), $urandom_range(0, 15), 0);
		push_req(make_req(REQ_INSERT, 16'h4321, 8'h22, 3'd7, 6'd0), $urandom_range(0, 15), 0);
		push_req(make_req(REQ_INSERT, 16'h0000, 8'h33, 3'd3, 6'd0), $urandom_range(0, 15), 0);
		push_req(make_req(REQ_LOOKUP, 16'hFFFF, 8'h00, 3'd0, 6'd0), $urandom_range(0, 15), 0);
		push_req(make_req(REQ_LOOKUP, 16'h7777, 8'h00, 3'd0, 6'd0), $urandom_range(0, 15), 0);
		push_req(make_req(REQ_READ, 16'h0000, 8'h00, 3'd0, 6'd0), $urandom_range(0, 15), 0);
		push_req(make_req(REQ_READ, 16'h0000, 8'h00, 3'd0, 6'd3), $urandom_range(0, 15), 0);
		push_req(make_req(REQ_READ, 16'h0000, 8'h00, 3'd0, 6'd4), $urandom_range(0, 15), 0);
		push_req(make_req(REQ_READ, 16'hFFFF, 8'hFF, 3'd7, 6'd63), $urandom_range(0, 15), 0);
		push_req(make_req(REQ_UPDATE, 16'h1234, 8'h7F, 3'd1, 6'd0), $urandom_range(0, 15), 0);
		push_req(make_req(REQ_UPDATE, 16'h7777, 8'h01, 3'd2, 6'd0), $urandom_range(0, 15), 0);
		push_req(make_req(REQ_UPDATE, 16'hFFFF, 8'h02, 3'd5, 6'd0), $urandom_range(0, 15), 0);
		push_req(make_req(REQ_UPDATE, 16'h8000, 8'h03, 3'd0, 6'd0), $urandom_range(0, 15), 0);
		push_req(make_req(REQ_REMOVE, 16'h0000, 8'h00, 3'd0, 6'd0), $urandom_range(0, 15), 0);
		push_req(make_req(REQ_REMOVE, 16'h0000, 8'h00, 3'd0, 6'd0), $urandom_range(0, 15), 0);
		push_req(make_req(REQ_FIRST_UNUSED, 16'h8000, 8'h44, 3'd1, 6'd1), $urandom_range(0, 15), 0);
		push_req(make_req(REQ_MID_UNUSED, 16'hFFFF, 8'h55, 3'd6, 6'd2), $urandom_range(0, 15), 0);
		push_req(make_req(REQ_LAST_UNUSED, 16'h1234, 8'h66, 3'd4, 6'd0), $urandom_range(0, 15), 0);
		push_req(make_req(REQ_LOOKUP, 16'h8000, 8'h00, 3'd0, 6'd0), $urandom_range(0, 15), 0);
		push_req(make_req(REQ_UPDATE, 16'hFFFF, 8'h00, 3'd1, 6'd0), $urandom_range(0, 15), 0);
		push_req(make_req(REQ_REMOVE, 16'hFFFF, 8'h00, 3'd0, 6'd0), $urandom_range(0, 15), 0);

		// small ticket pool so that hits, duplicates and a full table are common
		ticket_pool[0] = 16'h0000;
		ticket_pool[1] = 16'hFFFF;
		for (int i = 2; i < POOL_SIZE; i++)
			ticket_pool[i] = TICKET_W'($urandom_range(0, 16'hFFFF));

		// random blocks: fill, churn and drain mixes in turn
		for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
			mix = mix_t'(blk % 3);
			case (mix)
				MIX_FILL: begin
					ins_w = 75;
					rem_w = 5;
				end
				MIX_CHURN: begin
					ins_w = 35;
					rem_w = 25;
				end
				default: begin
					ins_w = 10;
					rem_w = 70;
				end
			endcase
			for (int n = 0; n < BLOCK_LEN; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < ins_w) begin
					op = REQ_INSERT;
				end else if (roll < ins_w + rem_w) begin
					op = REQ_REMOVE;
				end else begin
					v = $urandom_range(0, 19);
					if (v < 6)
						op = REQ_LOOKUP;
					else if (v < 12)
						op = REQ_UPDATE;
					else if (v < 18)
						op = REQ_READ;
					else
						op = REQ_W'($urandom_range(REQ_FIRST_UNUSED, REQ_LAST_UNUSED));
				end
				if ($urandom_range(0, 9) == 0)
					tk = TICKET_W'($urandom_range(0, 16'hFFFF));
				else
					tk = ticket_pool[$urandom_range(0, POOL_SIZE - 1)];
				if ($urandom_range(0, 9) == 0) begin
					v   = $urandom_range(0, 3);
					sev = (v == 0) ? 3'd0 : SEV_W'(v + 4);
				end else begin
					sev = SEV_W'($urandom_range(SEV_MIN, SEV_MAX));
				end
				if ($urandom_range(0, 6) == 0)
					pos = POS_W'($urandom_range(0, 63));
				else
					pos = POS_W'($urandom_range(0, TABLE_SIZE));
				gap = (blk % 5 == 2) ? 0 : $urandom_range(0, 15);
				push_req(make_req(op, tk, AGE_W'($urandom_range(0, 255)), sev, pos), gap,
					(n == 0) && (blk % 4 == 0));
			end
		end

		// reset
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// wait for all items out, all results back, then a quiet tail
		while (req_backlog.size() != 0 || req_if.valid)
			@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (2 * TABLE_SIZE + 8) @(posedge clk);
		if (results_due.size() != 0)
			fail_count++;

		$display("covered %0d requests: %0d ok, %0d full, %0d duplicate, %0d not found,",
			accepted_reqs, status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_DUP],
			status_seen[ST_NOTFOUND]);
		$display("%0d bad severity; table peaked at %0d of %0d entries, %0d failures",
			status_seen[ST_BADSEV], peak_fill, TABLE_SIZE, fail_count);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
`default_nettype wire
